// ===== hw/rtl/ufbs_pkg.sv =====
package ufbs_pkg;

  // Field widths
  localparam int BAUD_W = 22;
  localparam int EXP_W  = 4;
  localparam int SEL_W  = 12;
  localparam int ERR_W  = 25;

  // Stream word widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;

  // Divisor width of the shared divider: covers the baud rate and the
  // largest rate denominator, (4095 << 10) + 1024.
  localparam int DEN_W = 23;

  // Fixed-point one and the largest legal divisor
  localparam int FP_ONE  = 1024;
  localparam int SEL_MAX = 4095;

  // Exponent sweep bounds
  localparam logic signed [EXP_W-1:0] EXP_FIRST = -4'sd7;
  localparam logic signed [EXP_W-1:0] EXP_LAST  = 4'sd7;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SETUP = 8'b0000_0010,
    S_DIV1  = 8'b0000_0100,
    S_CHK1  = 8'b0000_1000,
    S_DIV2  = 8'b0001_0000,
    S_CHK2  = 8'b0010_0000,
    S_NEXT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage

// ===== hw/rtl/uart_fractional_baud_search.sv =====
// UART fractional baud divisor search.
//
// Input stream (s_axis_*): one word per request, carrying the wanted baud
// rate in bits per second. Output stream (m_axis_*): one word per request,
// carrying the best setting found over scale exponents -7..+7, trying
// double-speed (divide by 8) before normal (divide by 16) at each exponent.
//
// The block takes one request at a time. Each try runs one shared
// restoring divider for the quotient and, unless the try is skipped, again
// for the achieved rate, one quotient bit per cycle over NUM_W =
// clog2(CLOCK_HZ+1)+10 bits (35 at 32 MHz). A request makes at most 30
// tries and finishes early on an exact match. A zero baud rate makes no
// try and goes straight to the result.
//
// s_axis_tready is high only while the search is idle. The result sits in
// an output register, so a new request can start while the previous result
// waits; a finished search holds until that register is free. Reset drops
// any search in flight and any pending result.
module uart_fractional_baud_search #(
  parameter int CLOCK_HZ = 32000000
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [21:0] baud_rate, [23:22] zero
  input  logic [ufbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] double_speed, [4:1] scale_exponent, [16:5] divisor,
  // [24:17] ctrl_high_byte, [32:25] ctrl_low_byte, [57:33] rate_error,
  // [58] found, [63:59] zero
  output logic [ufbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ufbs_pkg::*;

  // Numerator width: CLOCK_HZ * 1024 at full width
  localparam int NUM_W = $clog2(CLOCK_HZ + 1) + 10;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] CLK_SCALED = NUM_W'(longint'(CLOCK_HZ) * FP_ONE);
  localparam logic [NUM_W-1:0] CLK_VAL    = NUM_W'(CLOCK_HZ);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(NUM_W - 1);

  state_t state;

  // Search context
  logic [BAUD_W-1:0]       baud;
  logic signed [EXP_W-1:0] expo;
  logic                    norm;      // 0: double speed, 1: normal mode
  logic [NUM_W-1:0]        num;
  logic [3:0]              kshift;    // log2 of the divisor step
  logic [SEL_W-1:0]        sel;

  // Shared divider
  logic [NUM_W-1:0] dvd;              // dividend in, quotient out
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsor;
  logic [CNT_W-1:0] cnt;

  // Best so far
  logic                    best_ds;
  logic signed [EXP_W-1:0] best_exp;
  logic [SEL_W-1:0]        best_sel;
  logic [NUM_W-1:0]        best_err;
  logic                    best_any;

  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  // Divider step
  logic [DEN_W:0]   rem_sh;
  logic             div_ge;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] dvd_next;

  always_comb begin
    rem_sh   = {rem, dvd[NUM_W-1]};
    div_ge   = rem_sh >= {1'b0, dsor};
    rem_next = div_ge ? DEN_W'(rem_sh - {1'b0, dsor}) : rem_sh[DEN_W-1:0];
    dvd_next = {dvd[NUM_W-2:0], div_ge};
  end

  // Try setup: numerator shift and divisor step
  logic [3:0]       shamt;
  logic [NUM_W-1:0] num_next;
  logic [3:0]       k_next;

  always_comb begin
    shamt    = 4'd3 + {3'd0, norm} + (expo[EXP_W-1] ? 4'd0 : {1'b0, expo[2:0]});
    num_next = CLK_SCALED >> shamt;
    k_next   = 4'd10 + (expo[EXP_W-1] ? 4'(expo) : 4'd0);
  end

  // Quotient check: selector and rate denominator
  logic [NUM_W-1:0] q_off;
  logic [NUM_W-1:0] sel_full;
  logic             q_low;
  logic             sel_big;
  logic [DEN_W-1:0] den;

  always_comb begin
    q_off    = dvd - NUM_W'(FP_ONE);
    q_low    = dvd < NUM_W'(FP_ONE);
    sel_full = q_off >> kshift;
    sel_big  = sel_full > NUM_W'(SEL_MAX);
    den      = (DEN_W'(sel_full[SEL_W-1:0]) << kshift) + DEN_W'(FP_ONE);
  end

  // Error of the current try
  logic [NUM_W-1:0] baud_ext;
  logic [NUM_W-1:0] err;

  always_comb begin
    baud_ext = NUM_W'(baud);
    err      = (dvd >= baud_ext) ? dvd - baud_ext : baud_ext - dvd;
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise on a finished search once the register is free, drop when taken
      if (state == S_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            baud     <= s_axis_tdata[BAUD_W-1:0];
            expo     <= EXP_FIRST;
            norm     <= 1'b0;
            best_ds  <= 1'b0;
            best_exp <= '0;
            best_sel <= '0;
            best_err <= CLK_VAL;
            best_any <= 1'b0;
            // A zero rate makes no try
            state    <= (s_axis_tdata[BAUD_W-1:0] == '0) ? S_DONE : S_SETUP;
          end
        end
        S_SETUP: begin
          num    <= num_next;
          kshift <= k_next;
          dvd    <= num_next;
          rem    <= '0;
          dsor   <= DEN_W'(baud);
          cnt    <= '0;
          state  <= S_DIV1;
        end
        S_DIV1, S_DIV2: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= (state == S_DIV1) ? S_CHK1 : S_CHK2;
          end
        end
        S_CHK1: begin
          // Skip on a negative offset or a divisor past 12 bits
          if (q_low || sel_big) begin
            state <= S_NEXT;
          end else begin
            sel   <= sel_full[SEL_W-1:0];
            dvd   <= num;
            rem   <= '0;
            dsor  <= den;
            cnt   <= '0;
            state <= S_DIV2;
          end
        end
        S_CHK2: begin
          state <= S_NEXT;
          if (err < best_err) begin
            best_ds  <= ~norm;
            best_exp <= expo;
            best_sel <= sel;
            best_err <= err;
            best_any <= 1'b1;
            // Exact match ends the sweep
            if (err == '0) begin
              state <= S_DONE;
            end
          end
        end
        S_NEXT: begin
          if (!norm) begin
            norm  <= 1'b1;
            state <= S_SETUP;
          end else begin
            norm <= 1'b0;
            if (expo == EXP_LAST) begin
              state <= S_DONE;
            end else begin
              expo  <= expo + 1'b1;
              state <= S_SETUP;
            end
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || m_axis_tready) begin
            out_data  <= {5'd0, best_any, best_err[ERR_W-1:0], best_sel[7:0],
                          best_exp, best_sel[SEL_W-1:8], best_sel, best_exp, best_ds};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ufbs_checker.sv =====
module ufbs_checker #(
  parameter int CLOCK_HZ = 32000000
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ufbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ufbs_pkg::*;

  localparam logic [ERR_W-1:0] CLK_ERR = ERR_W'(CLOCK_HZ);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");

  // Control bytes agree with exponent and divisor
  a_ctrl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[24:17] == {m_axis_tdata[4:1], m_axis_tdata[16:13]}
                   && m_axis_tdata[32:25] == m_axis_tdata[12:5])
    else $error("control bytes mismatch");

  // Nothing found gives a zero setting and the clock as error
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[58] |->
      m_axis_tdata[32:0] == '0 && m_axis_tdata[57:33] == CLK_ERR)
    else $error("bad empty result");

  // Padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:59] == '0)
    else $error("nonzero padding");

endmodule

bind uart_fractional_baud_search ufbs_checker #(.CLOCK_HZ(CLOCK_HZ)) u_ufbs_checker (.*);

// ===== verif/testbench.sv =====
module testbench;
  import ufbs_pkg::*;

  localparam int CLOCK_HZ = 32000000;
  localparam int N_DIRECTED = 25;
  localparam int N_RANDOM = 175;
  localparam int N_TOTAL = N_DIRECTED + N_RANDOM;
  // Leave plenty of room for a full search and for stalls.
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 64;

  // Result word fields, highest first, so the struct lines up with
  // m_axis_tdata[58:0].
  typedef struct packed {
    logic             found;
    logic [ERR_W-1:0] rate_error;
    logic [7:0]       ctrl_low;
    logic [7:0]       ctrl_high;
    logic [SEL_W-1:0] divisor;
    logic [EXP_W-1:0] scale_exp;
    logic             double_speed;
  } baud_setting_t;

  typedef struct packed {
    logic              typed;
    logic [BAUD_W-1:0] baud;
    baud_setting_t     want;
  } stim_row_t;

  // Nothing reachable: all zero but the error, which holds the clock rate.
  localparam baud_setting_t NO_SETTING = '{found: 1'b0, rate_error: ERR_W'(CLOCK_HZ),
                                           default: '0};
  // 4 Mbaud: exact hit on the first try, exponent -7 in double speed.
  localparam baud_setting_t TOP_RATE_SETTING = '{double_speed: 1'b1, scale_exp: 4'h9,
                                                 divisor: '0, ctrl_high: 8'h90,
                                                 ctrl_low: 8'h00, rate_error: '0,
                                                 found: 1'b1};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  baud_setting_t pending_settings[$];
  int            mismatches = 0;
  int            source_idle_pct = 0;
  int            sink_idle_pct = 0;
  int            quiet_cycles = 0;

  int unsigned std_rates[12] = '{300, 1200, 2400, 9600, 19200, 38400, 57600,
                                 115200, 230400, 460800, 921600, 3000000};

  // Directed table: extremes, common rates, and the cases that fall
  // through every try (zero rate, rate too low for the divisor, rate
  // above what the fastest mode reaches).
  stim_row_t directed_rows[N_DIRECTED] = '{
    '{1'b1, 22'd0,       NO_SETTING},
    '{1'b1, 22'd1,       NO_SETTING},
    '{1'b1, 22'd4194303, NO_SETTING},
    '{1'b1, 22'd4000000, TOP_RATE_SETTING},
    '{1'b0, 22'd2,       '0},
    '{1'b0, 22'd50,      '0},
    '{1'b0, 22'd300,     '0},
    '{1'b0, 22'd1200,    '0},
    '{1'b0, 22'd9600,    '0},
    '{1'b0, 22'd19200,   '0},
    '{1'b0, 22'd38400,   '0},
    '{1'b0, 22'd57600,   '0},
    '{1'b0, 22'd115200,  '0},
    '{1'b0, 22'd230400,  '0},
    '{1'b0, 22'd250000,  '0},
    '{1'b0, 22'd460800,  '0},
    '{1'b0, 22'd921600,  '0},
    '{1'b0, 22'd1000000, '0},
    '{1'b0, 22'd2000000, '0},
    '{1'b0, 22'd3000000, '0},
    '{1'b0, 22'd3999999, '0},
    '{1'b0, 22'd4000001, '0},
    '{1'b0, 22'd2097152, '0},
    '{1'b0, 22'h155555,  '0},
    '{1'b0, 22'h2AAAAA,  '0}
  };

  uart_fractional_baud_search #(
    .CLOCK_HZ(CLOCK_HZ)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Sweep exponents low to high, double speed before normal at each one,
  // and keep the first try with the strictly smallest error. Stop at an
  // exact hit. All arithmetic is 64-bit so nothing wraps.
  function automatic baud_setting_t search_baud(logic [BAUD_W-1:0] req);
    longint unsigned clk_hz, want, num, q, sel, rate, err, best_err, best_sel;
    int              e;
    int              mf;
    int              best_exp;
    bit              best_2x;
    bit              any;
    baud_setting_t   r;
    clk_hz   = CLOCK_HZ;
    want     = req;
    best_err = clk_hz;
    best_sel = 0;
    best_exp = 0;
    best_2x  = 1'b0;
    any      = 1'b0;
    if (want != 0) begin
      for (e = EXP_FIRST; e <= EXP_LAST; e++) begin
        if (any && best_err == 0) break;
        for (mf = 1; mf <= 2; mf++) begin
          if (e >= 0) begin
            num = ((clk_hz * FP_ONE) >> e) / 8 / mf;
            q = num / want;
            if (q < FP_ONE) continue;
            sel = (q - FP_ONE) / FP_ONE;
            if (sel > SEL_MAX) continue;
            rate = num / (sel * FP_ONE + FP_ONE);
          end else begin
            num = clk_hz * (FP_ONE / 8 / mf);
            q = num / want;
            if (q < FP_ONE) continue;
            sel = (q - FP_ONE) / (FP_ONE >> -e);
            if (sel > SEL_MAX) continue;
            rate = num / (((sel * FP_ONE) >> -e) + FP_ONE);
          end
          err = (want >= rate) ? want - rate : rate - want;
          if (err < best_err) begin
            best_2x  = (mf == 1);
            best_exp = e;
            best_sel = sel;
            best_err = err;
            any      = 1'b1;
            if (best_err == 0) break;
          end
        end
      end
    end
    r.double_speed = best_2x;
    r.scale_exp    = best_exp[3:0];
    r.divisor      = best_sel[11:0];
    r.ctrl_high    = {best_exp[3:0], best_sel[11:8]};
    r.ctrl_low     = best_sel[7:0];
    r.rate_error   = best_err[24:0];
    r.found        = any;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Source side: walk the directed table, then random rates. Switch the
  // idle mix in thirds: busy source / sparse sink, the reverse, then none.
  initial begin : source
    int              idx;
    int              n_gap;
    int              phase;
    logic [BAUD_W-1:0] rate;
    baud_setting_t   want;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (idx = 0; idx < N_TOTAL; idx++) begin
      phase = idx * 3 / N_TOTAL;
      case (phase)
        0: begin
          source_idle_pct = 17;
          sink_idle_pct   = 82;
        end
        1: begin
          source_idle_pct = 82;
          sink_idle_pct   = 17;
        end
        default: begin
          source_idle_pct = 0;
          sink_idle_pct   = 0;
        end
      endcase

      if (idx < N_DIRECTED) begin
        rate = directed_rows[idx].baud;
        want = directed_rows[idx].typed ? directed_rows[idx].want : search_baud(rate);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: rate = BAUD_W'($urandom_range(1, 4000000));
          // spread over decades; a shift down to zero is a valid request too
          4, 5: rate = BAUD_W'($urandom_range(1, 4000000) >> $urandom_range(0, 21));
          6, 7: rate = BAUD_W'(std_rates[$urandom_range(0, 11)]);
          // full field, rates past 4 Mbaud included
          8: rate = BAUD_W'($urandom());
          // near exact fractions of the clock
          default: rate = BAUD_W'(CLOCK_HZ / $urandom_range(8, 4096));
        endcase
        want = search_baud(rate);
      end

      n_gap = 0;
      while ($urandom_range(0, 99) < source_idle_pct) n_gap++;
      if (n_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (n_gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= IN_TDATA_W'(rate);
      do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
      pending_settings.push_back(want);
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every result, then let the block settle.
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** uart_fractional_baud_search: PASSED **");
    end else begin
      $display("** uart_fractional_baud_search: FAILED **");
    end
    $finish;
  end

  // Sink side: check each accepted word against the oldest expected
  // setting, then pick the next ready level.
  always @(posedge clk) begin : sink
    baud_setting_t got;
    baud_setting_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(baud_setting_t)-1:0];
      if (pending_settings.size() == 0) begin
        $error("result word with no request waiting: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_settings.pop_front();
        check_field("double_speed", want.double_speed, got.double_speed);
        check_field("scale_exponent", want.scale_exp, got.scale_exp);
        check_field("divisor", want.divisor, got.divisor);
        check_field("ctrl_high_byte", want.ctrl_high, got.ctrl_high);
        check_field("ctrl_low_byte", want.ctrl_low, got.ctrl_low);
        check_field("rate_error", want.rate_error, got.rate_error);
        check_field("found", want.found, got.found);
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** uart_fractional_baud_search: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
